// File: rtl/core/tlasp_pkg.sv
// Shared types, constants and the arctangent table of the two-link arm step planner.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package tlasp_pkg;

   localparam int unsigned LINK_W     = 15;
   localparam int unsigned MICRO_W    = 16;
   localparam int unsigned POS_W      = 16;
   localparam int unsigned STEP_W     = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned DIV_BITS   = 36;

   localparam logic [CSR_IDX_W-1:0] REG_UPPER_LINK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOWER_LINK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MICROSTEP  = 2'd2;

   localparam logic [LINK_W-1:0]  UPPER_LINK_RESET = 15'd25600;
   localparam logic [LINK_W-1:0]  LOWER_LINK_RESET = 15'd25600;
   localparam logic [MICRO_W-1:0] MICROSTEP_RESET  = 16'd7373;

   localparam logic signed [31:0] DEG90      = 32'sd5898240;
   localparam logic signed [31:0] NEG_DEG90  = -32'sd5898240;
   localparam logic signed [31:0] DEG180     = 32'sd11796480;
   localparam logic signed [31:0] NEG_DEG180 = -32'sd11796480;
   localparam logic signed [31:0] DEG360     = 32'sd23592960;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_LOAD,
      CMD_SQ_X, CMD_SQ_Y, CMD_SQ_L1, CMD_SQ_L2, CMD_L1L2,
      CMD_DSQ, CMD_NSQ, CMD_ESQ, CMD_MSQ, CMD_CHECK,
      CMD_CORD_LOAD, CMD_CORD_NORM, CMD_CORD_ROT, CMD_CORD_ITER, CMD_CORD_STORE,
      CMD_SQRT_LOAD, CMD_SQRT_STEP,
      CMD_TH1, CMD_TH2, CMD_DIFF,
      CMD_DIV_LOAD, CMD_DIV_STEP, CMD_DIV_STORE,
      CMD_COMMIT
   } cmd_type;

   typedef enum logic [1:0] {PASS_PHI, PASS_ALPHA, PASS_ELBOW} pass_type;

   typedef enum logic [0:0] {MOTOR_SHOULDER, MOTOR_ELBOW} motor_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_SQ_L1, ST_SQ_L2, ST_L1L2,
      ST_DSQ, ST_NSQ, ST_ESQ, ST_MSQ, ST_CHECK, ST_DECIDE,
      ST_CORD_LOAD, ST_CORD_NORM, ST_CORD_ROT, ST_CORD_ITER, ST_CORD_STORE,
      ST_SQRT_LOAD, ST_SQRT_STEP,
      ST_TH1, ST_TH2, ST_DIFF,
      ST_DIV_LOAD, ST_DIV_STEP, ST_DIV_STORE,
      ST_COMMIT
   } ctrl_state_type;

   typedef struct packed {
      cmd_type   op;
      pass_type  pass;
      motor_type motor;
   } cmd_bus_type;

   typedef struct packed {
      logic unreach;
      logic cord_zero;
      logic cord_normed;
      logic cord_last;
      logic sqrt_last;
      logic div_last;
   } status_type;

   // Rounded arctangent of 2^-i in units of 2^-16 degree.
   function automatic logic signed [31:0] arc_entry(input logic [4:0] idx);
      logic signed [31:0] val;
      unique case (idx)
         5'd0:  val = 32'sd2949120;
         5'd1:  val = 32'sd1740967;
         5'd2:  val = 32'sd919879;
         5'd3:  val = 32'sd466945;
         5'd4:  val = 32'sd234379;
         5'd5:  val = 32'sd117304;
         5'd6:  val = 32'sd58666;
         5'd7:  val = 32'sd29335;
         5'd8:  val = 32'sd14668;
         5'd9:  val = 32'sd7334;
         5'd10: val = 32'sd3667;
         5'd11: val = 32'sd1833;
         5'd12: val = 32'sd917;
         5'd13: val = 32'sd458;
         5'd14: val = 32'sd229;
         5'd15: val = 32'sd115;
         5'd16: val = 32'sd57;
         5'd17: val = 32'sd29;
         5'd18: val = 32'sd14;
         5'd19: val = 32'sd7;
         5'd20: val = 32'sd4;
         5'd21: val = 32'sd2;
         5'd22: val = 32'sd1;
         default: val = 32'sd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/tlasp_req_if.sv
// Target point channel: valid, ready and the target coordinates.
// Depends on tlasp_pkg for the field widths.
`default_nettype none

interface tlasp_req_if;
   import tlasp_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] target_x;
   logic signed [POS_W-1:0] target_y;

   modport source (output valid, output target_x, output target_y, input ready);
   modport sink (input valid, input target_x, input target_y, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tlasp_rsp_if.sv
// Result channel: valid, ready and the per-motor step counts and direction bits.
// Depends on tlasp_pkg for the field widths.
`default_nettype none

interface tlasp_rsp_if;
   import tlasp_pkg::*;
   logic              valid;
   logic              ready;
   logic [STEP_W-1:0] shoulder_steps;
   logic              shoulder_dir;
   logic [STEP_W-1:0] elbow_steps;
   logic              elbow_dir;
   logic              unreachable;

   modport source (output valid, output shoulder_steps, output shoulder_dir,
                   output elbow_steps, output elbow_dir, output unreachable,
                   input ready);
   modport sink (input valid, input shoulder_steps, input shoulder_dir,
                 input elbow_steps, input elbow_dir, input unreachable,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/core/tlasp_csr_if.sv
// Register write channel: valid, ready, register index and write data.
// Depends on tlasp_pkg for the field widths.
`default_nettype none

interface tlasp_csr_if;
   import tlasp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tlasp_datapath.sv
// Datapath of the arm step planner: multiplier, CORDIC, square root, divider,
// configuration and angle registers and the result register. Uses tlasp_pkg.
`default_nettype none

module tlasp_datapath #(
   parameter int unsigned CORDIC_ITERATIONS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tlasp_pkg::cmd_bus_type         cmd,
   output tlasp_pkg::status_type          status,
   input  logic signed [15:0]             req_target_x,
   input  logic signed [15:0]             req_target_y,
   input  logic                           csr_write,
   input  logic [tlasp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tlasp_pkg::CSR_DATA_W-1:0] csr_data,
   output logic [15:0]                    shoulder_steps,
   output logic                           shoulder_dir,
   output logic [15:0]                    elbow_steps,
   output logic                           elbow_dir,
   output logic                           unreachable
);
   import tlasp_pkg::*;

   localparam int unsigned CNT_W = $clog2(CORDIC_ITERATIONS);

   // Configuration and stored angles.
   logic [LINK_W-1:0]  upper_ff, lower_ff;
   logic [MICRO_W-1:0] micro_ff;
   logic signed [31:0] shoulder_ang_ff, elbow_ang_ff;

   // Work registers.
   logic signed [15:0] tx_ff, ty_ff;
   logic [63:0]        mul_p_ff;
   logic [31:0]        r2_ff;
   logic [29:0]        l1sq_ff, l1l2_ff;
   logic signed [33:0] n_ff, m_ff;
   logic [63:0]        dsq_ff, nsq_ff, esq_ff, msq_ff;
   logic               unreach_ff;
   logic signed [63:0] cx_ff, cy_ff;
   logic signed [31:0] cz_ff;
   logic [CNT_W-1:0]   cord_cnt_ff;
   logic [63:0]        sq_v_ff, sq_r_ff, sq_b_ff;
   logic [4:0]         sq_cnt_ff;
   logic signed [31:0] phi_ff, alpha_ff, e_ff, th1_ff, th2_ff;
   logic signed [33:0] d1_ff, d2_ff;
   logic [DIV_BITS-1:0] div_num_ff, div_q_ff;
   logic [16:0]        div_rem_ff;
   logic [33:0]        div_a_ff;
   logic               div_pos_ff;
   logic [5:0]         div_cnt_ff;
   logic [15:0]        sh_steps_ff, el_steps_ff;
   logic               sh_dir_ff, el_dir_ff;
   logic [15:0]        out_sh_steps_ff, out_el_steps_ff;
   logic               out_sh_dir_ff, out_el_dir_ff, out_unreach_ff;

   // Combinational helpers.
   logic [16:0]        ax, ay;
   logic [31:0]        n_mag, m_mag, mul_a, mul_b;
   logic [63:0]        mul_prod;
   logic [63:0]        abs_x, abs_y, mx;
   logic [4:0]         norm_shift, cord_idx;
   logic signed [63:0] xs, ys;
   logic signed [31:0] tab;
   logic [63:0]        sq_sum;
   logic signed [31:0] th_sum, th_wrap;
   logic signed [33:0] div_d;
   logic [33:0]        div_mag;
   logic [17:0]        rem_sh;
   logic [16:0]        den;
   logic               rem_ge;
   logic [15:0]        div_result;

   assign ax    = tx_ff[15] ? 17'(-{tx_ff[15], tx_ff}) : {1'b0, tx_ff};
   assign ay    = ty_ff[15] ? 17'(-{ty_ff[15], ty_ff}) : {1'b0, ty_ff};
   assign n_mag = n_ff[33] ? 32'(-n_ff) : 32'(n_ff);
   assign m_mag = m_ff[33] ? 32'(-m_ff) : 32'(m_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         CMD_SQ_X:  begin mul_a = 32'(ax); mul_b = 32'(ax); end
         CMD_SQ_Y:  begin mul_a = 32'(ay); mul_b = 32'(ay); end
         CMD_SQ_L1: begin mul_a = 32'(upper_ff); mul_b = 32'(upper_ff); end
         CMD_SQ_L2: begin mul_a = 32'(lower_ff); mul_b = 32'(lower_ff); end
         CMD_L1L2:  begin mul_a = 32'(upper_ff); mul_b = 32'(lower_ff); end
         CMD_DSQ:   begin mul_a = 32'(l1sq_ff); mul_b = r2_ff; end
         CMD_NSQ:   begin mul_a = n_mag; mul_b = n_mag; end
         CMD_ESQ:   begin mul_a = 32'(l1l2_ff); mul_b = 32'(l1l2_ff); end
         CMD_MSQ:   begin mul_a = m_mag; mul_b = m_mag; end
         default: ;
      endcase
   end

   assign mul_prod = {32'b0, mul_a} * {32'b0, mul_b};

   // CORDIC normalization and micro-rotation.
   assign abs_x = cx_ff[63] ? 64'(-cx_ff) : 64'(cx_ff);
   assign abs_y = cy_ff[63] ? 64'(-cy_ff) : 64'(cy_ff);
   assign mx    = (abs_x > abs_y) ? abs_x : abs_y;

   always_comb begin
      priority if (mx[63:42] == '0) begin
         norm_shift = 5'd16;
      end else if (mx[63:54] == '0) begin
         norm_shift = 5'd4;
      end else begin
         norm_shift = 5'd1;
      end
   end

   assign cord_idx = 5'(cord_cnt_ff);
   assign xs       = cx_ff >>> cord_idx;
   assign ys       = cy_ff >>> cord_idx;
   assign tab      = arc_entry(cord_idx);
   assign sq_sum   = sq_r_ff + sq_b_ff;

   always_comb begin
      th_sum = th1_ff + e_ff;
      priority if (th_sum > DEG180) begin
         th_wrap = th_sum - DEG360;
      end else if (th_sum <= NEG_DEG180) begin
         th_wrap = th_sum + DEG360;
      end else begin
         th_wrap = th_sum;
      end
   end

   assign div_d   = (cmd.motor == MOTOR_ELBOW) ? d2_ff : d1_ff;
   assign div_mag = div_d[33] ? 34'(-div_d) : 34'(div_d);
   assign rem_sh  = {div_rem_ff, div_num_ff[DIV_BITS-1]};
   assign den     = {micro_ff, 1'b0};
   assign rem_ge  = rem_sh >= {1'b0, den};

   always_comb begin
      priority if (micro_ff == '0) begin
         div_result = (div_a_ff != '0) ? 16'hFFFF : 16'h0000;
      end else if (div_q_ff[DIV_BITS-1:16] != '0) begin
         div_result = 16'hFFFF;
      end else begin
         div_result = div_q_ff[15:0];
      end
   end

   // Configuration and angle state.
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff        <= UPPER_LINK_RESET;
         lower_ff        <= LOWER_LINK_RESET;
         micro_ff        <= MICROSTEP_RESET;
         shoulder_ang_ff <= '0;
         elbow_ang_ff    <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_UPPER_LINK: upper_ff <= csr_data[LINK_W-1:0];
               REG_LOWER_LINK: lower_ff <= csr_data[LINK_W-1:0];
               REG_MICROSTEP:  micro_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.op == CMD_COMMIT && !unreach_ff) begin
            shoulder_ang_ff <= th1_ff;
            elbow_ang_ff    <= th2_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mul_p_ff <= mul_prod;
      unique case (cmd.op)
         CMD_LOAD: begin
            tx_ff <= req_target_x;
            ty_ff <= req_target_y;
         end
         CMD_SQ_Y:  r2_ff <= mul_p_ff[31:0];
         CMD_SQ_L1: r2_ff <= r2_ff + mul_p_ff[31:0];
         CMD_SQ_L2: l1sq_ff <= mul_p_ff[29:0];
         CMD_L1L2: begin
            n_ff <= $signed({2'b0, r2_ff}) + $signed({4'b0, l1sq_ff})
                    - $signed({4'b0, mul_p_ff[29:0]});
            m_ff <= $signed({2'b0, r2_ff}) - $signed({4'b0, l1sq_ff})
                    - $signed({4'b0, mul_p_ff[29:0]});
         end
         CMD_DSQ: l1l2_ff <= mul_p_ff[29:0];
         CMD_NSQ: dsq_ff <= {mul_p_ff[61:0], 2'b00};
         CMD_ESQ: nsq_ff <= mul_p_ff;
         CMD_MSQ: esq_ff <= {mul_p_ff[61:0], 2'b00};
         CMD_CHECK: begin
            msq_ff     <= mul_p_ff;
            unreach_ff <= (r2_ff == '0) || (nsq_ff > dsq_ff);
         end
         CMD_CORD_LOAD: begin
            cz_ff <= '0;
            unique case (cmd.pass)
               PASS_PHI: begin
                  cx_ff <= 64'(tx_ff);
                  cy_ff <= 64'(ty_ff);
               end
               PASS_ALPHA: begin
                  cx_ff <= 64'(n_ff);
                  cy_ff <= $signed(sq_r_ff);
               end
               default: begin
                  cx_ff <= 64'(m_ff);
                  cy_ff <= $signed(sq_r_ff);
               end
            endcase
         end
         CMD_CORD_NORM: begin
            if (mx[63:58] == '0 && mx != '0) begin
               cx_ff <= cx_ff <<< norm_shift;
               cy_ff <= cy_ff <<< norm_shift;
            end
         end
         CMD_CORD_ROT: begin
            cord_cnt_ff <= '0;
            if (cx_ff < 0) begin
               if (cy_ff >= 0) begin
                  cx_ff <= cy_ff;
                  cy_ff <= -cx_ff;
                  cz_ff <= DEG90;
               end else begin
                  cx_ff <= -cy_ff;
                  cy_ff <= cx_ff;
                  cz_ff <= NEG_DEG90;
               end
            end
         end
         CMD_CORD_ITER: begin
            cord_cnt_ff <= cord_cnt_ff + 1'b1;
            if (cy_ff >= 0) begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               cz_ff <= cz_ff + tab;
            end else begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               cz_ff <= cz_ff - tab;
            end
         end
         CMD_CORD_STORE: begin
            unique case (cmd.pass)
               PASS_PHI:   phi_ff <= cz_ff;
               PASS_ALPHA: alpha_ff <= cz_ff;
               default:    e_ff <= cz_ff;
            endcase
         end
         CMD_SQRT_LOAD: begin
            if (cmd.pass == PASS_ALPHA) begin
               sq_v_ff <= dsq_ff - nsq_ff;
            end else begin
               sq_v_ff <= (esq_ff > msq_ff) ? esq_ff - msq_ff : '0;
            end
            sq_r_ff   <= '0;
            sq_b_ff   <= 64'h4000_0000_0000_0000;
            sq_cnt_ff <= '0;
         end
         CMD_SQRT_STEP: begin
            sq_cnt_ff <= sq_cnt_ff + 1'b1;
            sq_b_ff   <= sq_b_ff >> 2;
            if (sq_v_ff >= sq_sum) begin
               sq_v_ff <= sq_v_ff - sq_sum;
               sq_r_ff <= (sq_r_ff >> 1) + sq_b_ff;
            end else begin
               sq_r_ff <= sq_r_ff >> 1;
            end
         end
         CMD_TH1: th1_ff <= phi_ff - alpha_ff;
         CMD_TH2: th2_ff <= th_wrap - th1_ff;
         CMD_DIFF: begin
            d1_ff <= 34'(th1_ff) - 34'(shoulder_ang_ff);
            d2_ff <= 34'(th2_ff) - 34'(elbow_ang_ff);
         end
         CMD_DIV_LOAD: begin
            div_a_ff   <= div_mag;
            div_pos_ff <= !div_d[33] && (div_d != '0);
            div_num_ff <= {1'b0, div_mag, 1'b0} + DIV_BITS'(micro_ff);
            div_rem_ff <= '0;
            div_q_ff   <= '0;
            div_cnt_ff <= '0;
         end
         CMD_DIV_STEP: begin
            div_cnt_ff <= div_cnt_ff + 1'b1;
            div_num_ff <= {div_num_ff[DIV_BITS-2:0], 1'b0};
            div_q_ff   <= {div_q_ff[DIV_BITS-2:0], rem_ge};
            div_rem_ff <= rem_ge ? 17'(rem_sh - {1'b0, den}) : rem_sh[16:0];
         end
         CMD_DIV_STORE: begin
            if (cmd.motor == MOTOR_SHOULDER) begin
               sh_steps_ff <= div_result;
               sh_dir_ff   <= div_pos_ff;
            end else begin
               el_steps_ff <= div_result;
               el_dir_ff   <= div_pos_ff;
            end
         end
         CMD_COMMIT: begin
            out_unreach_ff <= unreach_ff;
            if (unreach_ff) begin
               out_sh_steps_ff <= '0;
               out_sh_dir_ff   <= 1'b0;
               out_el_steps_ff <= '0;
               out_el_dir_ff   <= 1'b0;
            end else begin
               out_sh_steps_ff <= sh_steps_ff;
               out_sh_dir_ff   <= sh_dir_ff;
               out_el_steps_ff <= el_steps_ff;
               out_el_dir_ff   <= el_dir_ff;
            end
         end
         default: ;
      endcase
   end

   assign status.unreach     = unreach_ff;
   assign status.cord_zero   = (mx == '0);
   assign status.cord_normed = (mx[63:58] != '0);
   assign status.cord_last   = (cord_cnt_ff == CNT_W'(CORDIC_ITERATIONS - 1));
   assign status.sqrt_last   = (sq_cnt_ff == 5'd31);
   assign status.div_last    = (div_cnt_ff == 6'(DIV_BITS - 1));

   assign shoulder_steps = out_sh_steps_ff;
   assign shoulder_dir   = out_sh_dir_ff;
   assign elbow_steps    = out_el_steps_ff;
   assign elbow_dir      = out_el_dir_ff;
   assign unreachable    = out_unreach_ff;

endmodule

`default_nettype wire

// File: rtl/core/tlasp_controller.sv
// Sequencer of the arm step planner: handshakes and the command stream to the datapath.
// Uses tlasp_pkg for the state, command and status types.
`default_nettype none

module tlasp_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tlasp_pkg::cmd_bus_type cmd,
   input  tlasp_pkg::status_type  status
);
   import tlasp_pkg::*;

   ctrl_state_type state_ff, state_in;
   pass_type       pass_ff, pass_in;
   motor_type      motor_ff, motor_in;
   logic           out_valid_ff, out_valid_in;
   logic           commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= PASS_PHI;
         motor_ff     <= MOTOR_SHOULDER;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         motor_ff     <= motor_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pass_in   = pass_ff;
      motor_in  = motor_ff;
      cmd.op    = CMD_NONE;
      cmd.pass  = pass_ff;
      cmd.motor = motor_ff;
      req_ready = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = CMD_LOAD;
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X:  begin cmd.op = CMD_SQ_X;  state_in = ST_SQ_Y;  end
         ST_SQ_Y:  begin cmd.op = CMD_SQ_Y;  state_in = ST_SQ_L1; end
         ST_SQ_L1: begin cmd.op = CMD_SQ_L1; state_in = ST_SQ_L2; end
         ST_SQ_L2: begin cmd.op = CMD_SQ_L2; state_in = ST_L1L2;  end
         ST_L1L2:  begin cmd.op = CMD_L1L2;  state_in = ST_DSQ;   end
         ST_DSQ:   begin cmd.op = CMD_DSQ;   state_in = ST_NSQ;   end
         ST_NSQ:   begin cmd.op = CMD_NSQ;   state_in = ST_ESQ;   end
         ST_ESQ:   begin cmd.op = CMD_ESQ;   state_in = ST_MSQ;   end
         ST_MSQ:   begin cmd.op = CMD_MSQ;   state_in = ST_CHECK; end
         ST_CHECK: begin cmd.op = CMD_CHECK; state_in = ST_DECIDE; end
         ST_DECIDE: begin
            if (status.unreach) begin
               state_in = ST_COMMIT;
            end else begin
               pass_in  = PASS_PHI;
               state_in = ST_CORD_LOAD;
            end
         end
         ST_CORD_LOAD: begin cmd.op = CMD_CORD_LOAD; state_in = ST_CORD_NORM; end
         ST_CORD_NORM: begin
            cmd.op = CMD_CORD_NORM;
            priority if (status.cord_zero) begin
               state_in = ST_CORD_STORE;
            end else if (status.cord_normed) begin
               state_in = ST_CORD_ROT;
            end else begin
               state_in = ST_CORD_NORM;
            end
         end
         ST_CORD_ROT: begin cmd.op = CMD_CORD_ROT; state_in = ST_CORD_ITER; end
         ST_CORD_ITER: begin
            cmd.op = CMD_CORD_ITER;
            if (status.cord_last) begin
               state_in = ST_CORD_STORE;
            end
         end
         ST_CORD_STORE: begin
            cmd.op = CMD_CORD_STORE;
            unique case (pass_ff)
               PASS_PHI:   begin pass_in = PASS_ALPHA; state_in = ST_SQRT_LOAD; end
               PASS_ALPHA: begin pass_in = PASS_ELBOW; state_in = ST_SQRT_LOAD; end
               PASS_ELBOW: state_in = ST_TH1;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_SQRT_LOAD: begin cmd.op = CMD_SQRT_LOAD; state_in = ST_SQRT_STEP; end
         ST_SQRT_STEP: begin
            cmd.op = CMD_SQRT_STEP;
            if (status.sqrt_last) begin
               state_in = ST_CORD_LOAD;
            end
         end
         ST_TH1: begin cmd.op = CMD_TH1; state_in = ST_TH2; end
         ST_TH2: begin cmd.op = CMD_TH2; state_in = ST_DIFF; end
         ST_DIFF: begin
            cmd.op   = CMD_DIFF;
            motor_in = MOTOR_SHOULDER;
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin cmd.op = CMD_DIV_LOAD; state_in = ST_DIV_STEP; end
         ST_DIV_STEP: begin
            cmd.op = CMD_DIV_STEP;
            if (status.div_last) begin
               state_in = ST_DIV_STORE;
            end
         end
         ST_DIV_STORE: begin
            cmd.op = CMD_DIV_STORE;
            if (motor_ff == MOTOR_SHOULDER) begin
               motor_in = MOTOR_ELBOW;
               state_in = ST_DIV_LOAD;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.op   = CMD_COMMIT;
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      out_valid_in = commit || (out_valid_ff && !rsp_ready);
   end

   assign rsp_valid = out_valid_ff;

`ifndef ASSERT_OFF
   a_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready)
      else $error("input taken while an item is in work");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.op == CMD_COMMIT |=> rsp_valid)
      else $error("committed result not presented");

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.op == CMD_COMMIT |-> (!out_valid_ff || rsp_ready))
      else $error("result register overwritten before transfer");
`endif

endmodule

`default_nettype wire

// File: rtl/core/two_link_arm_step_planner.sv
// Sequence: for a reachable target the block runs three CORDIC passes (load, normalize,
// pre-rotation, CORDIC_ITERATIONS steps and store) with a square root before the second
// and third, then two dividers; an atan2 that gets a zero vector goes from normalize
// straight to store, and an out-of-reach target goes from the reach check to the result.
// Throughput: one item at a time; the next input is taken in the cycle after the result
// is registered, even while it waits. Reset (synchronous, active high) restores the
// registers to their defaults, zeroes both stored angles and empties the result register.
`default_nettype none

module two_link_arm_step_planner #(
   parameter int unsigned CORDIC_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   tlasp_req_if.sink   req_bus,
   tlasp_rsp_if.source rsp_bus,
   tlasp_csr_if.sink   csr_bus
);
   import tlasp_pkg::*;

   cmd_bus_type cmd;
   status_type  status;
   logic        csr_write;

   // Register writes always accepted; the user must issue them only while idle, unchecked.
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   // The controller owns both handshakes and walks the datapath through the solution:
   // squares and products on the shared multiplier, the reach check, then atan2 of the
   // target, the shoulder offset and the elbow angle, and finally the two step counts.
   tlasp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the configuration, the stored joint angles and the result
   // register, so a finished result can wait for its transfer while the next item works.
   tlasp_datapath #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_target_x   (req_bus.target_x),
      .req_target_y   (req_bus.target_y),
      .csr_write      (csr_write),
      .csr_index      (csr_bus.index),
      .csr_data       (csr_bus.data),
      .shoulder_steps (rsp_bus.shoulder_steps),
      .shoulder_dir   (rsp_bus.shoulder_dir),
      .elbow_steps    (rsp_bus.elbow_steps),
      .elbow_dir      (rsp_bus.elbow_dir),
      .unreachable    (rsp_bus.unreachable)
   );

endmodule

`default_nettype wire
